// File: rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types, constants and helpers for the geometry string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  // Accumulator width; values saturate at 2^VALUE_BITS - 1
  localparam int VALUE_BITS = 16;
  localparam int FIELD_BITS = 16;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [FIELD_BITS-1:0] field_t;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_VALIGN = 2'd1;
  localparam logic [1:0] ERR_HALIGN = 2'd2;
  localparam logic [1:0] ERR_GEOM   = 2'd3;

  // Characters of the grammar
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LO_C    = 8'h63;
  localparam logic [7:0] CH_UP_C    = 8'h43;
  localparam logic [7:0] CH_LO_L    = 8'h6C;
  localparam logic [7:0] CH_UP_L    = 8'h4C;
  localparam logic [7:0] CH_LO_X    = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;

  // Keyword tables, zero padded: index is alignment code
  localparam int KW_COUNT = 4;
  localparam int KW_SLOTS = 7;
  localparam int KW_MAX_POS = 6;

  localparam logic [7:0] VERT_WORDS [KW_COUNT][KW_SLOTS] = '{
    '{"t", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "o", "t", "t", "o", "m", 8'h00},
    '{"m", "i", "d", "d", "l", "e", 8'h00},
    '{"n", "o", "n", "e", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [7:0] HORIZ_WORDS [KW_COUNT][KW_SLOTS] = '{
    '{"l", "e", "f", "t", 8'h00, 8'h00, 8'h00},
    '{"c", "e", "n", "t", "e", "r", 8'h00},
    '{"r", "i", "g", "h", "t", 8'h00, 8'h00},
    '{"n", "o", "n", "e", 8'h00, 8'h00, 8'h00}
  };

  // One result item
  typedef struct packed {
    logic       ok;
    field_t     width;
    field_t     height;
    logic [3:0] size_flags;
    field_t     x_offset;
    field_t     y_offset;
    logic [1:0] offset_signs;
    logic [1:0] vert_align;
    logic [1:0] horiz_align;
    logic [5:0] present_mask;
    logic [1:0] error_code;
  } result_t;

  // acc * 10 + d, saturated
  function automatic value_t add_digit(input value_t acc, input logic [3:0] d);
    logic [VALUE_BITS+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{VALUE_BITS{1'b0}}, d};
    if (|v[VALUE_BITS+3:VALUE_BITS]) begin
      return '1;
    end
    return v[VALUE_BITS-1:0];
  endfunction

  // Fit an accumulator into a result field (mask or zero extend)
  function automatic field_t to_field(input value_t v);
    logic [VALUE_BITS+FIELD_BITS-1:0] e;
    e = {{FIELD_BITS{1'b0}}, v};
    return e[FIELD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/gsp_parser.sv
// ----------------------------------------------------------------------------
// gsp_parser
// Parser state and the per-byte transition; forms the result at the terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       char_in,
  output gsp_pkg::result_t      result
);
  import gsp_pkg::*;

  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_WDIG  = 4'd1;
  localparam logic [3:0] PH_WSUF  = 4'd2;
  localparam logic [3:0] PH_HDIG  = 4'd3;
  localparam logic [3:0] PH_HSUF  = 4'd4;
  localparam logic [3:0] PH_XDIG  = 4'd5;
  localparam logic [3:0] PH_YDIG  = 4'd6;
  localparam logic [3:0] PH_VKW   = 4'd7;
  localparam logic [3:0] PH_VDONE = 4'd8;
  localparam logic [3:0] PH_HKW   = 4'd9;
  localparam logic [3:0] PH_HDONE = 4'd10;
  localparam logic [3:0] PH_ERR   = 4'd11;

  logic [3:0] phase, phase_next;
  value_t     width_acc, width_acc_next;
  value_t     height_acc, height_acc_next;
  value_t     xoff_acc, xoff_acc_next;
  value_t     yoff_acc, yoff_acc_next;
  logic [5:0] flag_bits, flag_bits_next;
  logic [3:0] kw_cand, kw_cand_next;
  logic [2:0] kw_pos, kw_pos_next;
  logic [3:0] align_vals, align_vals_next;
  logic [5:0] present_bits, present_bits_next;
  logic [1:0] error_reg, error_reg_next;

  logic       is_digit;
  logic [3:0] digit_val;
  logic       is_suffix;
  logic       try_tail;
  logic       x_ok;
  logic       y_ok;
  logic       horiz_kw;
  logic [3:0] kw_live;
  logic [3:0] kw_done;
  logic [2:0] kw_pos_inc;
  logic [1:0] kw_code;
  logic       kw_fail;

  // Classify the byte
  assign is_digit  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign digit_val = char_in[3:0];
  assign is_suffix = (char_in == CH_PERCENT) || (char_in == CH_LO_C) ||
                     (char_in == CH_UP_C) || (char_in == CH_LO_L) || (char_in == CH_UP_L);

  // Match the byte against the keyword candidates still alive
  assign horiz_kw   = (phase == PH_HKW);
  assign kw_pos_inc = kw_pos + 3'd1;

  always_comb begin
    kw_live = '0;
    kw_done = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (kw_cand[i] && (kw_pos < 3'(KW_MAX_POS))) begin
        if (horiz_kw) begin
          kw_live[i] = (HORIZ_WORDS[i][kw_pos] == char_in);
          kw_done[i] = kw_live[i] && (HORIZ_WORDS[i][kw_pos_inc] == CH_NUL);
        end else begin
          kw_live[i] = (VERT_WORDS[i][kw_pos] == char_in);
          kw_done[i] = kw_live[i] && (VERT_WORDS[i][kw_pos_inc] == CH_NUL);
        end
      end
    end
  end

  assign kw_fail = (kw_live == 4'b0000);

  // Last completed keyword wins
  always_comb begin
    kw_code = 2'd0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (kw_done[i]) begin
        kw_code = 2'(i);
      end
    end
  end

  // Next state for one byte
  always_comb begin
    phase_next        = phase;
    width_acc_next    = width_acc;
    height_acc_next   = height_acc;
    xoff_acc_next     = xoff_acc;
    yoff_acc_next     = yoff_acc;
    flag_bits_next    = flag_bits;
    kw_cand_next      = kw_cand;
    kw_pos_next       = kw_pos;
    align_vals_next   = align_vals;
    present_bits_next = present_bits;
    error_reg_next    = error_reg;
    try_tail          = 1'b0;
    x_ok              = 1'b0;
    y_ok              = 1'b0;

    if (char_in == CH_NUL) begin
      // Return to the start of a string
      phase_next        = PH_START;
      width_acc_next    = '0;
      height_acc_next   = '0;
      xoff_acc_next     = '0;
      yoff_acc_next     = '0;
      flag_bits_next    = '0;
      kw_cand_next      = 4'hF;
      kw_pos_next       = '0;
      align_vals_next   = '0;
      present_bits_next = '0;
      error_reg_next    = ERR_NONE;
    end else begin
      unique case (phase)
        PH_START: begin
          if (is_digit) begin
            present_bits_next[0] = 1'b1;
            width_acc_next       = add_digit('0, digit_val);
            phase_next           = PH_WDIG;
          end else begin
            try_tail = 1'b1;
            x_ok     = 1'b1;
          end
        end
        PH_WDIG, PH_WSUF: begin
          if ((phase == PH_WDIG) && is_digit) begin
            width_acc_next = add_digit(width_acc, digit_val);
          end else if ((phase == PH_WDIG) && is_suffix) begin
            if (char_in == CH_PERCENT) flag_bits_next[0] = 1'b1;
            else flag_bits_next[2] = 1'b1;
            phase_next = PH_WSUF;
          end else if ((char_in == CH_LO_X) || (char_in == CH_UP_X)) begin
            present_bits_next[1] = 1'b1;
            phase_next           = PH_HDIG;
          end else begin
            try_tail = 1'b1;
            x_ok     = 1'b1;
          end
        end
        PH_HDIG: begin
          if (is_digit) begin
            height_acc_next = add_digit(height_acc, digit_val);
          end else if (is_suffix) begin
            if (char_in == CH_PERCENT) flag_bits_next[1] = 1'b1;
            else flag_bits_next[3] = 1'b1;
            phase_next = PH_HSUF;
          end else begin
            try_tail = 1'b1;
            x_ok     = 1'b1;
          end
        end
        PH_HSUF: begin
          try_tail = 1'b1;
          x_ok     = 1'b1;
        end
        PH_XDIG: begin
          if (is_digit) begin
            xoff_acc_next = add_digit(xoff_acc, digit_val);
          end else begin
            try_tail = 1'b1;
            y_ok     = 1'b1;
          end
        end
        PH_YDIG: begin
          if (is_digit) begin
            yoff_acc_next = add_digit(yoff_acc, digit_val);
          end else begin
            try_tail = 1'b1;
          end
        end
        PH_VKW, PH_HKW: begin
          kw_cand_next = kw_live;
          kw_pos_next  = kw_pos_inc;
          if (kw_fail) begin
            error_reg_next = horiz_kw ? ERR_HALIGN : ERR_VALIGN;
            phase_next     = PH_ERR;
          end else if (|kw_done) begin
            if (horiz_kw) begin
              align_vals_next[3:2] = kw_code;
              phase_next           = PH_HDONE;
            end else begin
              align_vals_next[1:0] = kw_code;
              phase_next           = PH_VDONE;
            end
          end
        end
        PH_VDONE: begin
          if (char_in == CH_SLASH) begin
            present_bits_next[5] = 1'b1;
            kw_cand_next         = 4'hF;
            kw_pos_next          = '0;
            phase_next           = PH_HKW;
          end else begin
            error_reg_next = ERR_GEOM;
            phase_next     = PH_ERR;
          end
        end
        PH_HDONE: begin
          error_reg_next = ERR_GEOM;
          phase_next     = PH_ERR;
        end
        default: begin
          phase_next = PH_ERR;
        end
      endcase

      // Offsets and the valign marker at the start of a string or after a size or offset
      if (try_tail) begin
        if (((char_in == CH_PLUS) || (char_in == CH_MINUS)) && (x_ok || y_ok)) begin
          if (x_ok) begin
            present_bits_next[2] = 1'b1;
            if (char_in == CH_MINUS) flag_bits_next[4] = 1'b1;
            phase_next = PH_XDIG;
          end else begin
            present_bits_next[3] = 1'b1;
            if (char_in == CH_MINUS) flag_bits_next[5] = 1'b1;
            phase_next = PH_YDIG;
          end
        end else if (char_in == CH_STAR) begin
          present_bits_next[4] = 1'b1;
          kw_cand_next         = 4'hF;
          kw_pos_next          = '0;
          phase_next           = PH_VKW;
        end else begin
          error_reg_next = ERR_GEOM;
          phase_next     = PH_ERR;
        end
      end
    end
  end

  // Advance the state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      width_acc    <= '0;
      height_acc   <= '0;
      xoff_acc     <= '0;
      yoff_acc     <= '0;
      flag_bits    <= '0;
      kw_cand      <= 4'hF;
      kw_pos       <= '0;
      align_vals   <= '0;
      present_bits <= '0;
      error_reg    <= ERR_NONE;
    end else if (step) begin
      phase        <= phase_next;
      width_acc    <= width_acc_next;
      height_acc   <= height_acc_next;
      xoff_acc     <= xoff_acc_next;
      yoff_acc     <= yoff_acc_next;
      flag_bits    <= flag_bits_next;
      kw_cand      <= kw_cand_next;
      kw_pos       <= kw_pos_next;
      align_vals   <= align_vals_next;
      present_bits <= present_bits_next;
      error_reg    <= error_reg_next;
    end
  end

  // Form the result seen at the terminator; errors zero every other field
  always_comb begin
    result = '0;
    if (phase == PH_VKW) begin
      result.error_code = ERR_VALIGN;
    end else if (phase == PH_HKW) begin
      result.error_code = ERR_HALIGN;
    end else if (phase == PH_ERR) begin
      result.error_code = error_reg;
    end else begin
      result.ok           = 1'b1;
      result.width        = to_field(width_acc);
      result.height       = to_field(height_acc);
      result.size_flags   = flag_bits[3:0];
      result.x_offset     = to_field(xoff_acc);
      result.y_offset     = to_field(yoff_acc);
      result.offset_signs = flag_bits[5:4];
      result.vert_align   = align_vals[1:0];
      result.horiz_align  = align_vals[3:2];
      result.present_mask = present_bits;
      result.error_code   = ERR_NONE;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gsp_result_reg.sv
// ----------------------------------------------------------------------------
// gsp_result_reg
// Output register for the result channel; holds a result until it transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_result_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire gsp_pkg::result_t result_in,
  input  wire logic             stall,
  output logic                  free,
  output logic                  valid,
  output gsp_pkg::result_t      result
);
  import gsp_pkg::*;

  // Slot can take a new result when empty or when the held one transfers
  assign free = !valid || !stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/geometry_string_parser_top.sv
// ----------------------------------------------------------------------------
// geometry_string_parser_top
// Byte-stream geometry string parser with valid/stall channels.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while item_stall is low and answers each
// zero byte with one result; other bytes produce nothing. A byte is captured
// in an input register, and from there it updates the parser state and, for
// a terminator, the result register. Bytes keep flowing while a result waits
// on the output; only a terminator that finds the result register still
// occupied is held in the input register until that result transfers.
`default_nettype none

module geometry_string_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [7:0]  char_in,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             ok,
  output logic [15:0]      width,
  output logic [15:0]      height,
  output logic [3:0]       size_flags,
  output logic [15:0]      x_offset,
  output logic [15:0]      y_offset,
  output logic [1:0]       offset_signs,
  output logic [1:0]       vert_align,
  output logic [1:0]       horiz_align,
  output logic [5:0]       present_mask,
  output logic [1:0]       error_code
);
  import gsp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_reg;
  logic       out_free;
  logic       fire;
  logic       load;
  result_t    step_result;
  result_t    held_result;

  // Process the held byte; a terminator also needs the result slot
  assign fire       = byte_valid && ((byte_reg != CH_NUL) || out_free);
  assign load       = fire && (byte_reg == CH_NUL);
  assign item_stall = byte_valid && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!item_stall) begin
      byte_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      byte_reg <= char_in;
    end
  end

  gsp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (fire),
    .char_in (byte_reg),
    .result  (step_result)
  );

  gsp_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .result_in (step_result),
    .stall     (result_stall),
    .free      (out_free),
    .valid     (result_valid),
    .result    (held_result)
  );

  // Drive result fields
  assign ok           = held_result.ok;
  assign width        = held_result.width;
  assign height       = held_result.height;
  assign size_flags   = held_result.size_flags;
  assign x_offset     = held_result.x_offset;
  assign y_offset     = held_result.y_offset;
  assign offset_signs = held_result.offset_signs;
  assign vert_align   = held_result.vert_align;
  assign horiz_align  = held_result.horiz_align;
  assign present_mask = held_result.present_mask;
  assign error_code   = held_result.error_code;

  // ok and the error code always agree
  a_ok_vs_error: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (ok == (error_code == ERR_NONE)))
    else $error("ok disagrees with error_code");

  // A failed parse reports no fields
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !ok) |-> ((width == '0) && (present_mask == '0) &&
                               (x_offset == '0) && (offset_signs == '0)))
    else $error("error result carries field data");

  // Height needs a width, halign needs a valign
  a_mask_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((!present_mask[1] || present_mask[0]) &&
                      (!present_mask[5] || present_mask[4])))
    else $error("present_mask has an impossible combination");

  // A terminator blocked by a waiting result is held, not lost
  a_term_held: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && (byte_reg == CH_NUL) && result_valid && result_stall) |=>
    (byte_valid && (byte_reg == CH_NUL)))
    else $error("blocked terminator dropped");

endmodule

`default_nettype wire
